@@ src/gbc_pkg.sv @@
package gbc_pkg;

  localparam int unsigned LineMax = 128;
  localparam int unsigned ColW    = $clog2(LineMax);
  localparam int unsigned RowW    = 12;
  localparam int unsigned NTaps   = 25;
  localparam int unsigned TapW    = 5;
  localparam int unsigned NCh     = 3;
  localparam int unsigned AddrW   = 6;

  localparam logic [2:0] REG_WA = 3'd0;
  localparam logic [2:0] REG_WB = 3'd1;
  localparam logic [2:0] REG_WC = 3'd2;
  localparam logic [2:0] REG_WL = 3'd3;
  localparam logic [2:0] REG_BIAS = 3'd4;
  localparam logic [2:0] REG_FW = 3'd5;
  localparam logic [2:0] REG_FH = 3'd6;

  localparam logic [12:0] GAUSS_K [NTaps] = '{
    13'd900,  13'd1770, 13'd2220, 13'd1770, 13'd900,
    13'd1770, 13'd3481, 13'd4366, 13'd3481, 13'd1770,
    13'd2220, 13'd4366, 13'd5476, 13'd4366, 13'd2220,
    13'd1770, 13'd3481, 13'd4366, 13'd3481, 13'd1770,
    13'd900,  13'd1770, 13'd2220, 13'd1770, 13'd900
  };

  typedef logic [7:0] pix_t [NCh];

  typedef struct packed {
    logic [63:0] wa;
    logic [63:0] wb;
    logic [63:0] wc;
    logic [7:0]  wl;
    logic [15:0] bias;
    logic [7:0]  fw;
    logic [11:0] fh;
  } cfg_t;

  typedef struct packed {
    logic            accept;
    logic [ColW-1:0] addr;
    logic            push_raw;
    logic            gauss_step;
    logic            push_blur;
    logic            conv_step;
    logic            load_out;
    logic            last;
    logic [TapW-1:0] tap;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

@@ src/gbc_if.sv @@
interface gbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_ch0;
  logic [7:0] in_ch1;
  logic [7:0] in_ch2;
  modport source (output valid, in_ch0, in_ch1, in_ch2, input ready);
  modport sink (input valid, in_ch0, in_ch1, in_ch2, output ready);
endinterface

interface gbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_ch0;
  logic [7:0] out_ch1;
  logic [7:0] out_ch2;
  logic       frame_end;
  modport source (output valid, out_ch0, out_ch1, out_ch2, frame_end, input ready);
  modport sink (input valid, out_ch0, out_ch1, out_ch2, frame_end, output ready);
endinterface

@@ src/gbc_cfg.sv @@
module gbc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbc_pkg::AddrW-1:0]  paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  output gbc_pkg::cfg_t              cfg
);

  gbc_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr;

  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wa   <= '0;
      cfg_r.wb   <= '0;
      cfg_r.wc   <= '0;
      cfg_r.wl   <= '0;
      cfg_r.bias <= '0;
      cfg_r.fw   <= 8'd72;
      cfg_r.fh   <= 12'd72;
    end else if (wr) begin
      unique case (idx)
        gbc_pkg::REG_WA:   cfg_r.wa   <= pwdata;
        gbc_pkg::REG_WB:   cfg_r.wb   <= pwdata;
        gbc_pkg::REG_WC:   cfg_r.wc   <= pwdata;
        gbc_pkg::REG_WL:   cfg_r.wl   <= pwdata[7:0];
        gbc_pkg::REG_BIAS: cfg_r.bias <= pwdata[15:0];
        gbc_pkg::REG_FW:   cfg_r.fw   <= pwdata[7:0];
        gbc_pkg::REG_FH:   cfg_r.fh   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gbc_pkg::REG_WA:   prdata = cfg_r.wa;
      gbc_pkg::REG_WB:   prdata = cfg_r.wb;
      gbc_pkg::REG_WC:   prdata = cfg_r.wc;
      gbc_pkg::REG_WL:   prdata = {56'd0, cfg_r.wl};
      gbc_pkg::REG_BIAS: prdata = {48'd0, cfg_r.bias};
      gbc_pkg::REG_FW:   prdata = {56'd0, cfg_r.fw};
      gbc_pkg::REG_FH:   prdata = {52'd0, cfg_r.fh};
      default:           prdata = '0;
    endcase
  end

endmodule

@@ src/gbc_ctrl.sv @@
module gbc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  gbc_pkg::cfg_t  cfg,
  input  gbc_pkg::stat_t st,
  output gbc_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH  = 3'd1;
  localparam logic [2:0] S_GAUSS = 3'd2;
  localparam logic [2:0] S_BPUSH = 3'd3;
  localparam logic [2:0] S_CONV  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic [gbc_pkg::ColW-1:0]    col_r, col_nxt, ccol_r;
  logic [gbc_pkg::RowW-1:0]    row_r, row_nxt;
  logic [gbc_pkg::TapW-1:0]    tap_r, tap_nxt;
  logic                        blur_r, outp_r, last_r;
  logic [7:0]                  w;
  logic [12:0]                 h;
  logic                        accept, line_end, frame_last;
  logic [7:0]                  col_p1;
  logic [12:0]                 row_p1;

  always_comb begin
    priority if (cfg.fw < 8'd9) w = 8'd9;
    else if (cfg.fw > 8'(gbc_pkg::LineMax)) w = 8'(gbc_pkg::LineMax);
    else w = cfg.fw;
    h = (cfg.fh < 12'd9) ? 13'd9 : {1'b0, cfg.fh};
  end

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign col_p1     = {1'b0, col_r} + 8'd1;
  assign row_p1     = {1'b0, row_r} + 13'd1;
  assign line_end   = (col_p1 >= w);
  assign frame_last = line_end && (row_p1 >= h);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (line_end) begin
        col_nxt = '0;
        row_nxt = (row_p1 >= h) ? '0 : row_p1[gbc_pkg::RowW-1:0];
      end else begin
        col_nxt = col_p1[gbc_pkg::ColW-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_PUSH;
      S_PUSH: begin
        tap_nxt   = '0;
        state_nxt = blur_r ? S_GAUSS : S_IDLE;
      end
      S_GAUSS: begin
        tap_nxt = tap_r + 1'b1;
        if (tap_r == 5'(gbc_pkg::NTaps - 1)) state_nxt = S_BPUSH;
      end
      S_BPUSH: begin
        tap_nxt   = '0;
        state_nxt = outp_r ? S_CONV : S_IDLE;
      end
      S_CONV: begin
        tap_nxt = tap_r + 1'b1;
        if (tap_r == 5'(gbc_pkg::NTaps - 1)) state_nxt = S_OUT;
      end
      S_OUT: if (st.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      tap_r   <= '0;
      blur_r  <= 1'b0;
      outp_r  <= 1'b0;
      last_r  <= 1'b0;
      ccol_r  <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      tap_r   <= tap_nxt;
      if (accept) begin
        ccol_r <= col_r;
        blur_r <= (col_r >= 7'd4) && (row_r >= 12'd4);
        outp_r <= (col_r >= 7'd8) && (row_r >= 12'd8);
        last_r <= frame_last;
      end
    end
  end

  always_comb begin
    cmd.accept     = accept;
    cmd.addr       = (state_r == S_IDLE) ? col_r : ccol_r;
    cmd.push_raw   = (state_r == S_PUSH);
    cmd.gauss_step = (state_r == S_GAUSS);
    cmd.push_blur  = (state_r == S_BPUSH);
    cmd.conv_step  = (state_r == S_CONV);
    cmd.load_out   = (state_r == S_OUT) && st.out_free;
    cmd.last       = last_r;
    cmd.tap        = tap_r;
  end

endmodule

@@ src/gbc_dp.sv @@
module gbc_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  gbc_pkg::cfg_t  cfg,
  input  gbc_pkg::cmd_t  cmd,
  output gbc_pkg::stat_t st,
  input  logic [7:0]     in_ch0,
  input  logic [7:0]     in_ch1,
  input  logic [7:0]     in_ch2,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_ch0,
  output logic [7:0]     out_ch1,
  output logic [7:0]     out_ch2,
  output logic           frame_end
);

  localparam int unsigned LW = 24;

  logic [4*LW-1:0] raw_mem [gbc_pkg::LineMax];
  logic [4*LW-1:0] blur_mem [gbc_pkg::LineMax];
  logic [4*LW-1:0] raw_rd_r, blur_rd_r;
  logic [LW-1:0]   raw_win_r [gbc_pkg::NTaps];
  logic [LW-1:0]   blur_win_r [gbc_pkg::NTaps];
  logic [LW-1:0]   pix_r, blur_pix;
  logic [23:0]     sum_r [gbc_pkg::NCh];
  logic [15:0]     acc_r [gbc_pkg::NCh];
  logic [199:0]    wts;
  logic [7:0]      wt;
  logic [LW-1:0]   rsel, bsel;
  logic            out_valid_r, last_out_r;
  logic [7:0]      out_r [gbc_pkg::NCh];

  assign wts  = {cfg.wl, cfg.wc, cfg.wb, cfg.wa};
  assign wt   = wts[8*cmd.tap +: 8];
  assign rsel = raw_win_r[cmd.tap];
  assign bsel = blur_win_r[cmd.tap];
  assign blur_pix = {sum_r[2][23:16], sum_r[1][23:16], sum_r[0][23:16]};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r     <= {in_ch2, in_ch1, in_ch0};
      raw_rd_r  <= raw_mem[cmd.addr];
      blur_rd_r <= blur_mem[cmd.addr];
    end
    if (cmd.push_raw) raw_mem[cmd.addr] <= {pix_r, raw_rd_r[4*LW-1:LW]};
    if (cmd.push_blur) blur_mem[cmd.addr] <= {blur_pix, blur_rd_r[4*LW-1:LW]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gbc_pkg::NTaps; i++) begin
        raw_win_r[i]  <= '0;
        blur_win_r[i] <= '0;
      end
    end else begin
      for (int ky = 0; ky < 5; ky++) begin
        if (cmd.push_raw) begin
          for (int kx = 0; kx < 4; kx++) raw_win_r[ky*5+kx] <= raw_win_r[ky*5+kx+1];
          raw_win_r[ky*5+4] <= (ky < 4) ? raw_rd_r[ky*LW +: LW] : pix_r;
        end
        if (cmd.push_blur) begin
          for (int kx = 0; kx < 4; kx++) blur_win_r[ky*5+kx] <= blur_win_r[ky*5+kx+1];
          blur_win_r[ky*5+4] <= (ky < 4) ? blur_rd_r[ky*LW +: LW] : blur_pix;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < gbc_pkg::NCh; c++) begin
      if (cmd.push_raw) sum_r[c] <= '0;
      else if (cmd.gauss_step)
        sum_r[c] <= sum_r[c] +
                    ({16'd0, rsel[8*c +: 8]} * {11'd0, gbc_pkg::GAUSS_K[cmd.tap]});
      if (cmd.push_blur) acc_r[c] <= cfg.bias;
      else if (cmd.conv_step)
        acc_r[c] <= acc_r[c] + ({8'd0, bsel[8*c +: 8]} * {8'd0, wt});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int c = 0; c < gbc_pkg::NCh; c++) out_r[c] <= acc_r[c][15:8];
      last_out_r <= cmd.last;
    end
  end

  assign st.out_free = !out_valid_r || out_ready;
  assign out_valid   = out_valid_r;
  assign out_ch0     = out_r[0];
  assign out_ch1     = out_r[1];
  assign out_ch2     = out_r[2];
  assign frame_end   = last_out_r;

endmodule

@@ src/gaussian_blur_then_conv5x5_top.sv @@
// No new word is taken until the last one's steps end: raw push, 25-step
// Gaussian loop, blur push, 25-step weight loop, result load; a word outside
// the blur area ends at the raw push, outside the result area at the blur push.
// The result register frees the input side while a word waits to be taken.
// Reset: synchronous, active low; clears control, counters and windows, and
// sets config to its defaults. Line stores are not cleared.
module gaussian_blur_then_conv5x5_top (
  input  logic                      clk,
  input  logic                      rst_n,
  gbc_in_if.sink                    in_px,
  gbc_out_if.source                 out_px,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gbc_pkg::AddrW-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);

  gbc_pkg::cfg_t  cfg;
  gbc_pkg::cmd_t  cmd;
  gbc_pkg::stat_t st;

  gbc_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  gbc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_px.valid), .in_ready(in_px.ready), .cfg, .st, .cmd
  );

  gbc_dp u_dp (
    .clk, .rst_n, .cfg, .cmd, .st,
    .in_ch0(in_px.in_ch0), .in_ch1(in_px.in_ch1), .in_ch2(in_px.in_ch2),
    .out_valid(out_px.valid), .out_ready(out_px.ready),
    .out_ch0(out_px.out_ch0), .out_ch1(out_px.out_ch1), .out_ch2(out_px.out_ch2),
    .frame_end(out_px.frame_end)
  );

endmodule

@@ src/gbc_chk.sv @@
module gbc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_ch0,
  input logic       pready
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ch0))
    else $error("stalled result dropped or changed");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind gaussian_blur_then_conv5x5_top gbc_chk u_gbc_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_px.valid), .in_ready(in_px.ready),
  .out_valid(out_px.valid), .out_ready(out_px.ready),
  .out_ch0(out_px.out_ch0), .pready(pready)
);

@@ test/gbc_checker.sv @@
module gbc_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  gbc_in_if                         in_px,
  gbc_out_if                        out_px,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [gbc_pkg::AddrW-1:0] paddr,
  input  logic [63:0]               pwdata,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic       frame_end;
  } filt_px_t;

  localparam int unsigned BLUR_TAP [5] = '{30, 59, 74, 59, 30};

  filt_px_t filt_q [$];

  logic [7:0]  lines [2][4][gbc_pkg::LineMax][gbc_pkg::NCh];
  logic [7:0]  win   [2][5][5][gbc_pkg::NCh];
  int unsigned col_pos;
  int unsigned row_pos;

  logic [63:0] wa, wb, wc;
  logic [7:0]  wl;
  logic [15:0] bias_r;
  logic [7:0]  fw;
  logic [11:0] fh;

  function automatic logic [7:0] tap_of(int unsigned t);
    logic [63:0] w64;
    if (t == 24) return wl;
    w64 = (t < 8) ? wa : (t < 16) ? wb : wc;
    return w64[(t % 8) * 8 +: 8];
  endfunction

  task automatic push_col(input int s, input int unsigned c,
                          input logic [gbc_pkg::NCh-1:0][7:0] p);
    for (int ch = 0; ch < gbc_pkg::NCh; ch++) begin
      for (int ky = 0; ky < 5; ky++) begin
        for (int kx = 0; kx < 4; kx++) win[s][ky][kx][ch] = win[s][ky][kx+1][ch];
        win[s][ky][4][ch] = (ky < 4) ? lines[s][ky][c][ch] : p[ch];
      end
      for (int ky = 0; ky < 3; ky++) lines[s][ky][c][ch] = lines[s][ky+1][c][ch];
      lines[s][3][c][ch] = p[ch];
    end
  endtask

  task automatic filter_word(input logic [gbc_pkg::NCh-1:0][7:0] pix);
    int unsigned w, h, c, r;
    int unsigned sum;
    logic [15:0] acc;
    logic [gbc_pkg::NCh-1:0][7:0] blur;
    logic [gbc_pkg::NCh-1:0][7:0] res;
    logic line_end, last;
    filt_px_t e;
    w = fw; h = fh; c = col_pos; r = row_pos;
    if (w < 9) w = 9;
    if (w > gbc_pkg::LineMax) w = gbc_pkg::LineMax;
    if (h < 9) h = 9;
    if (c >= gbc_pkg::LineMax) c = gbc_pkg::LineMax - 1;
    push_col(0, c, pix);
    line_end = (c + 1 >= w);
    last = line_end && (r + 1 >= h);
    if (c >= 4 && r >= 4) begin
      for (int ch = 0; ch < gbc_pkg::NCh; ch++) begin
        sum = 0;
        for (int ky = 0; ky < 5; ky++)
          for (int kx = 0; kx < 5; kx++)
            sum += win[0][ky][kx][ch] * BLUR_TAP[kx] * BLUR_TAP[ky];
        blur[ch] = sum[23:16];
      end
      push_col(1, c, blur);
      if (c >= 8 && r >= 8) begin
        for (int ch = 0; ch < gbc_pkg::NCh; ch++) begin
          acc = bias_r;
          for (int t = 0; t < 25; t++)
            acc = acc + ({8'd0, win[1][t/5][t%5][ch]} * {8'd0, tap_of(t)});
          res[ch] = acc[15:8];
        end
        e.ch0 = res[0]; e.ch1 = res[1]; e.ch2 = res[2]; e.frame_end = last;
        filt_q.insert(filt_q.size(), e);
      end
    end
    if (line_end) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : (r + 1) % 4096;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk) begin
    filt_px_t e;
    if (!rst_n) begin
      for (int s = 0; s < 2; s++)
        for (int a = 0; a < 5; a++)
          for (int b = 0; b < 5; b++)
            for (int ch = 0; ch < gbc_pkg::NCh; ch++) win[s][a][b][ch] = '0;
      for (int s = 0; s < 2; s++)
        for (int a = 0; a < 4; a++)
          for (int b = 0; b < gbc_pkg::LineMax; b++)
            for (int ch = 0; ch < gbc_pkg::NCh; ch++) lines[s][a][b][ch] = '0;
      col_pos = 0; row_pos = 0;
      wa = '0; wb = '0; wc = '0; wl = '0; bias_r = '0; fw = 8'd72; fh = 12'd72;
      filt_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          gbc_pkg::REG_WA:   wa = pwdata;
          gbc_pkg::REG_WB:   wb = pwdata;
          gbc_pkg::REG_WC:   wc = pwdata;
          gbc_pkg::REG_WL:   wl = pwdata[7:0];
          gbc_pkg::REG_BIAS: bias_r = pwdata[15:0];
          gbc_pkg::REG_FW:   fw = pwdata[7:0];
          gbc_pkg::REG_FH:   fh = pwdata[11:0];
          default: ;
        endcase
      end
      if (out_px.valid && out_px.ready) begin
        if (filt_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h %h %h fe=%b", out_px.out_ch0,
                                     out_px.out_ch1, out_px.out_ch2, out_px.frame_end);
        end else begin
          e = filt_q.pop_front();
          if (e.ch0 !== out_px.out_ch0 || e.ch1 !== out_px.out_ch1 ||
              e.ch2 !== out_px.out_ch2 || e.frame_end !== out_px.frame_end) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp %h %h %h fe=%b got %h %h %h fe=%b",
                       e.ch0, e.ch1, e.ch2, e.frame_end, out_px.out_ch0,
                       out_px.out_ch1, out_px.out_ch2, out_px.frame_end);
          end
        end
      end
      if (in_px.valid && in_px.ready)
        filter_word({in_px.in_ch2, in_px.in_ch1, in_px.in_ch0});
      pending = filt_q.size();
    end
  end
endmodule

@@ test/gaussian_blur_then_conv5x5_top_tb.sv @@
module gaussian_blur_then_conv5x5_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      psel, penable, pwrite;
  logic [gbc_pkg::AddrW-1:0] paddr;
  logic [63:0]               pwdata;
  logic [63:0]               prdata;
  logic                      pready;
  int                        errors;
  int                        pending;
  bit                        idling = 1'b1;
  int                        word_cnt = 0;

  gbc_in_if  in_px ();
  gbc_out_if out_px ();

  gaussian_blur_then_conv5x5_top i_dut (
    .clk, .rst_n, .in_px(in_px.sink), .out_px(out_px.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  gbc_checker i_checker (
    .clk, .rst_n, .in_px, .out_px, .psel, .penable, .pwrite, .pready,
    .paddr, .pwdata, .errors, .pending
  );

  always #5 clk = ~clk;

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= gbc_pkg::AddrW'({idx, 3'b000}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] sample(int k);
    logic [7:0] pat [4] = '{8'h00, 8'hFF, 8'hAA, 8'h55};
    if (word_cnt < 25) return pat[(word_cnt + k) % 4];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_frame(input int w, input int h);
    for (int i = 0; i < w * h; i++) begin
      if (idling && $urandom_range(0, 7) == 0) begin
        in_px.valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      in_px.valid  <= 1'b1;
      in_px.in_ch0 <= sample(0);
      in_px.in_ch1 <= sample(1);
      in_px.in_ch2 <= sample(2);
      word_cnt++;
      do @(posedge clk); while (!in_px.ready);
    end
    in_px.valid <= 1'b0;
  endtask

  task automatic run_frame(input logic [63:0] wa, wb, wc, input logic [7:0] wl,
                           input logic [15:0] bias, input logic [7:0] fw,
                           input logic [11:0] fh);
    int w, h;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    reg_write(gbc_pkg::REG_WA, wa);
    reg_write(gbc_pkg::REG_WB, wb);
    reg_write(gbc_pkg::REG_WC, wc);
    reg_write(gbc_pkg::REG_WL, {56'd0, wl});
    reg_write(gbc_pkg::REG_BIAS, {48'd0, bias});
    reg_write(gbc_pkg::REG_FW, {56'd0, fw});
    reg_write(gbc_pkg::REG_FH, {52'd0, fh});
    w = (fw < 9) ? 9 : (fw > gbc_pkg::LineMax) ? gbc_pkg::LineMax : fw;
    h = (fh < 9) ? 9 : fh;
    send_frame(w, h);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    out_px.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 3) == 0) begin
        out_px.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_px.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin
    int n;
    rst_n <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_px.valid <= 1'b0; in_px.in_ch0 <= '0; in_px.in_ch1 <= '0; in_px.in_ch2 <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_frame('1, '1, '1, 8'hFF, 16'hFFFF, 8'd0, 12'd0);
    run_frame('0, '0, '0, 8'h00, 16'h0000, 8'd9, 12'd9);
    run_frame(rnd64(), rnd64(), rnd64(), 8'($urandom), 16'($urandom), 8'd255, 12'd9);
    n = 0;
    while (word_cnt < 1400) begin
      if (word_cnt > 1250) idling = 1'b0;
      run_frame(rnd64(), rnd64(), rnd64(), 8'($urandom), 16'($urandom),
                8'($urandom_range(9, 16)), 12'($urandom_range(9, 14)));
      n++;
    end
    n = 0;
    while (pending != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("gaussian_blur_then_conv5x5_top_tb: PASS");
    end else begin
      $display("gaussian_blur_then_conv5x5_top_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("gaussian_blur_then_conv5x5_top_tb: FAIL");
    $finish;
  end
endmodule

@@ files.f @@
src/gbc_pkg.sv
src/gbc_if.sv
src/gbc_cfg.sv
src/gbc_ctrl.sv
src/gbc_dp.sv
src/gaussian_blur_then_conv5x5_top.sv
src/gbc_chk.sv
test/gbc_checker.sv
test/gaussian_blur_then_conv5x5_top_tb.sv
